/* rtl/cgr_pkg.sv */
// cgr_pkg: shared types, constants and helpers for the color gradient ramp
// used by cgr_front, cgr_back and color_gradient_ramp; no dependencies
package cgr_pkg;

    localparam int KEY_MAX_DEF = 8;
    localparam int TIME_W      = 17;
    localparam int COLOR_W     = 32;
    localparam int KCNT_W      = 4;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [TIME_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [KCNT_W-1:0] KCNT_RESET = 4'd2;
    localparam logic [KCNT_W-1:0] KCNT_MIN   = 4'd2;

    // word index of the key count register (paddr bit 2)
    localparam logic REG_KEY_COUNT = 1'b0;

    localparam logic [COLOR_W-1:0] COLOR_OPAQUE_WHITE = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COLOR_CLEAR_WHITE  = 32'hFFFF_FF00;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_EVAL  = 1'b1
    } t_func;

    typedef struct packed {
        logic               func;
        logic [2:0]         key_index;
        logic [TIME_W-1:0]  key_time;
        logic [COLOR_W-1:0] key_color;
        logic [TIME_W-1:0]  life_ratio;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_out_item;

    // classified item held in the queue between front and back
    typedef struct packed {
        t_func              kind;
        logic [2:0]         idx;
        logic [TIME_W-1:0]  ktime;
        logic [COLOR_W-1:0] color;
        logic [TIME_W-1:0]  ratio;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SRCH,
        BS_DIV,
        BS_MIX,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic idle;
        logic out_full;
    } t_back_stat;

    function automatic logic [TIME_W-1:0] sat_one(input logic [TIME_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic logic [TIME_W-1:0] reset_time(input int slot);
        return (slot == 1) ? ONE_Q16 : '0;
    endfunction

    function automatic logic [COLOR_W-1:0] reset_color(input int slot);
        logic [COLOR_W-1:0] c;
        c = '0;
        if (slot == 0) begin
            c = COLOR_OPAQUE_WHITE;
        end else if (slot == 1) begin
            c = COLOR_CLEAR_WHITE;
        end
        return c;
    endfunction

endpackage

/* rtl/cgr_ram.sv */
// cgr_ram: generic single write port, single read port RAM with registered read
// no dependencies
module cgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cgr_front.sv */
// cgr_front: accepts input transfers, classifies and clamps them, queues them
// depends on cgr_pkg
module cgr_front #(
    parameter int MAX_KEYS = cgr_pkg::KEY_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  cgr_pkg::t_in_item i_item,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output cgr_pkg::t_cmd    o_cmd
);

    cgr_pkg::t_cmd r_buf [2];
    cgr_pkg::t_cmd w_cmd;
    logic [1:0]    r_cnt;
    logic          r_wp;
    logic          r_rp;
    logic          w_drop;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd.kind  = cgr_pkg::t_func'(i_item.func);
        w_cmd.idx   = i_item.key_index;
        w_cmd.ktime = cgr_pkg::sat_one(i_item.key_time);
        w_cmd.color = i_item.key_color;
        w_cmd.ratio = cgr_pkg::sat_one(i_item.life_ratio);
    end

    // writes to slots beyond the table are dropped here
    assign w_drop = (w_cmd.kind == cgr_pkg::FUNC_WRITE) && (int'(i_item.key_index) >= MAX_KEYS);

    assign o_item_ready = (r_cnt != 2'd2);
    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign o_cmd        = r_buf[r_rp];
    assign w_push       = i_item_valid && o_item_ready && !w_drop;
    assign w_pop        = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_cmd;
        end
    end

endmodule

/* rtl/cgr_back.sv */
// cgr_back: key table, segment search, 2-bit-per-cycle divider, channel mix, result register
// depends on cgr_pkg and cgr_ram
module cgr_back #(
    parameter int MAX_KEYS = cgr_pkg::KEY_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cgr_pkg::KCNT_W-1:0]    i_key_count,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  cgr_pkg::t_cmd                 i_cmd,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output cgr_pkg::t_out_item            o_res,
    output cgr_pkg::t_back_stat           o_stat
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int TW = cgr_pkg::TIME_W;
    localparam int CW = cgr_pkg::COLOR_W;
    localparam int RW = TW + CW;
    localparam int PW = 8 + TW;

    function automatic logic [TW:0] div_step(input logic [TW-1:0] rem,
                                              input logic [TW-1:0] den);
        logic [TW:0] sh;
        logic [TW:0] dx;
        sh = {rem, 1'b0};
        dx = {1'b0, den};
        if (sh >= dx) begin
            return {1'b1, TW'(sh - dx)};
        end else begin
            return {1'b0, sh[TW-1:0]};
        end
    endfunction

    cgr_pkg::t_bstate r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_last, n_last;
    logic [TW-1:0]    r_ratio, n_ratio;
    logic [TW-1:0]    r_t0, n_t0;
    logic [CW-1:0]    r_c0, n_c0;
    logic [CW-1:0]    r_c1, n_c1;
    logic [TW-1:0]    r_rem, n_rem;
    logic [TW-1:0]    r_den, n_den;
    logic [TW-1:0]    r_q, n_q;
    logic [2:0]       r_dcnt, n_dcnt;
    logic [2:0]       r_ch, n_ch;
    logic [PW-1:0]    r_p0, n_p0;
    logic [PW-1:0]    r_p1, n_p1;
    logic [CW-1:0]    r_res, n_res;
    logic             r_out_valid;
    logic [CW-1:0]    r_out;

    logic [(1 << AW)-1:0] r_vld;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [RW-1:0]    w_rdata;
    logic [TW-1:0]    w_cur_t;
    logic [CW-1:0]    w_cur_c;
    logic             w_hit;
    logic [TW-1:0]    w_num;
    logic [TW-1:0]    w_den;
    logic [AW-1:0]    w_last;
    logic             w_out_free;
    logic [TW:0]      w_st1;
    logic [TW:0]      w_st0;
    logic [9:0]       w_sum;
    logic [7:0]       w_mix;

    // last key in use, from the clamped key count
    always_comb begin
        if (i_key_count < cgr_pkg::KCNT_MIN) begin
            w_last = AW'(1);
        end else if (int'(i_key_count) > MAX_KEYS) begin
            w_last = AW'(MAX_KEYS - 1);
        end else begin
            w_last = AW'(i_key_count - 4'd1);
        end
    end

    assign o_cmd_ready = (r_state == cgr_pkg::BS_IDLE);
    assign w_we        = o_cmd_ready && i_cmd_valid && (i_cmd.kind == cgr_pkg::FUNC_WRITE);
    assign w_waddr     = AW'(i_cmd.idx);
    assign w_raddr     = (r_state == cgr_pkg::BS_IDLE) ? '0 : r_idx + AW'(1);

    cgr_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_cmd.ktime, i_cmd.color}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // slots never written read as their reset key
    assign w_cur_t = r_rd_vld ? w_rdata[RW-1:CW] : cgr_pkg::reset_time(int'(r_rd_addr));
    assign w_cur_c = r_rd_vld ? w_rdata[CW-1:0]  : cgr_pkg::reset_color(int'(r_rd_addr));

    assign w_hit = (r_ratio >= r_t0) && (r_ratio <= w_cur_t);
    assign w_num = w_cur_t - r_ratio;
    assign w_den = w_cur_t - r_t0;

    assign w_st1 = div_step(r_rem, r_den);
    assign w_st0 = div_step(w_st1[TW-1:0], r_den);

    assign w_sum = {1'b0, r_p0[PW-1:16]} + {1'b0, r_p1[PW-1:16]};
    assign w_mix = (w_sum > 10'd255) ? 8'hFF : w_sum[7:0];

    assign w_out_free = !r_out_valid || i_res_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cgr_pkg::BS_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == cgr_pkg::FUNC_EVAL) begin
                    n_state = cgr_pkg::BS_SRCH;
                end
            end
            cgr_pkg::BS_SRCH: begin
                if (r_idx != '0) begin
                    if (w_hit) begin
                        n_state = (w_den == '0) ? cgr_pkg::BS_MIX : cgr_pkg::BS_DIV;
                    end else if (r_idx == r_last) begin
                        n_state = cgr_pkg::BS_DONE;
                    end
                end
            end
            cgr_pkg::BS_DIV: begin
                if (r_dcnt == 3'd0) begin
                    n_state = cgr_pkg::BS_MIX;
                end
            end
            cgr_pkg::BS_MIX: begin
                if (r_ch == 3'd4) begin
                    n_state = cgr_pkg::BS_DONE;
                end
            end
            cgr_pkg::BS_DONE: begin
                if (w_out_free) begin
                    n_state = cgr_pkg::BS_IDLE;
                end
            end
            default: n_state = cgr_pkg::BS_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_idx   = r_idx;
        n_last  = r_last;
        n_ratio = r_ratio;
        n_t0    = r_t0;
        n_c0    = r_c0;
        n_c1    = r_c1;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        n_dcnt  = r_dcnt;
        n_ch    = r_ch;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_res   = r_res;
        unique case (r_state)
            cgr_pkg::BS_IDLE: begin
                n_idx   = '0;
                n_last  = w_last;
                n_ratio = i_cmd.ratio;
            end
            cgr_pkg::BS_SRCH: begin
                if (r_idx == '0) begin
                    n_t0  = w_cur_t;
                    n_c0  = w_cur_c;
                    n_idx = r_idx + AW'(1);
                end else if (w_hit) begin
                    n_c1   = w_cur_c;
                    n_den  = w_den;
                    n_dcnt = 3'd7;
                    n_ch   = 3'd0;
                    if (w_den == '0) begin
                        n_q   = '0;
                        n_rem = '0;
                    end else if (w_num >= w_den) begin
                        n_q   = cgr_pkg::ONE_Q16;
                        n_rem = w_num - w_den;
                    end else begin
                        n_q   = '0;
                        n_rem = w_num;
                    end
                end else if (r_idx == r_last) begin
                    n_res = w_cur_c;
                end else begin
                    n_t0  = w_cur_t;
                    n_c0  = w_cur_c;
                    n_idx = r_idx + AW'(1);
                end
            end
            cgr_pkg::BS_DIV: begin
                n_rem  = w_st0[TW-1:0];
                n_q    = {r_q[TW-1], r_q[TW-4:0], w_st1[TW], w_st0[TW]};
                n_dcnt = r_dcnt - 3'd1;
            end
            cgr_pkg::BS_MIX: begin
                if (r_ch != 3'd4) begin
                    n_p0 = PW'(r_c0[CW-1 -: 8]) * PW'(r_q);
                    n_p1 = PW'(r_c1[CW-1 -: 8]) * PW'(cgr_pkg::ONE_Q16 - r_q);
                    n_c0 = r_c0 << 8;
                    n_c1 = r_c1 << 8;
                end
                if (r_ch != 3'd0) begin
                    n_res = {r_res[CW-9:0], w_mix};
                end
                n_ch = r_ch + 3'd1;
            end
            cgr_pkg::BS_DONE: begin
                n_res = r_res;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cgr_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == cgr_pkg::BS_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_last    <= n_last;
        r_ratio   <= n_ratio;
        r_t0      <= n_t0;
        r_c0      <= n_c0;
        r_c1      <= n_c1;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_q       <= n_q;
        r_dcnt    <= n_dcnt;
        r_ch      <= n_ch;
        r_p0      <= n_p0;
        r_p1      <= n_p1;
        r_res     <= n_res;
        r_rd_vld  <= r_vld[w_raddr];
        r_rd_addr <= w_raddr;
        if (r_state == cgr_pkg::BS_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_res         = cgr_pkg::t_out_item'(r_out);
    assign o_stat.idle     = (r_state == cgr_pkg::BS_IDLE);
    assign o_stat.out_full = r_out_valid;

endmodule

/* rtl/color_gradient_ramp.sv */
// color_gradient_ramp: top level of the piecewise linear RGBA gradient
// depends on cgr_pkg, cgr_front, cgr_back (and cgr_ram through cgr_back)
//
// usage
// - item channel (i_item_valid / o_item_ready / i_item): one transfer is either a key
//   write (func 0: slot, Q1.16 time, RGBA color) or an evaluate (func 1: Q1.16 ratio)
// - result channel (o_res_valid / i_res_ready / o_res): one RGBA transfer per evaluate,
//   nothing for a key write
// - APB port: one register at byte address 0, key_count (4 bits, resets to 2);
//   the user must write it only while the block is idle; the block does not enforce it
// - an evaluate reads keys from the key RAM, one key read per cycle, until it finds
//   the segment that holds the ratio, then runs the 2-bit division and the per-channel
//   mixing, else gives the last key's color; a key write goes straight into the key RAM
// - the back end works one item at a time; a two-entry queue in front keeps
//   taking transfers until it holds two items
// - reset clears the queue, the result valid flag and the slot valid bits, so the
//   table reads as its default two-key ramp (opaque white to transparent white)
// - a stalled receiver holds the result in its register; the back end finishes the
//   next evaluate and then waits, while the queue keeps filling up to two items
module color_gradient_ramp #(
    parameter int MAX_KEYS = cgr_pkg::KEY_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item channel
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  cgr_pkg::t_in_item           i_item,
    // result channel
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output cgr_pkg::t_out_item          o_res,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cgr_pkg::APB_AW-1:0]  paddr,
    input  logic [cgr_pkg::APB_DW-1:0]  pwdata,
    output logic [cgr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [cgr_pkg::KCNT_W-1:0] r_key_count;
    logic                       w_cfg_wr;
    logic                       w_cmd_valid;
    logic                       w_cmd_ready;
    cgr_pkg::t_cmd              w_cmd;
    cgr_pkg::t_back_stat        w_bstat;

    // configuration register, written on the access phase of an APB write
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= cgr_pkg::KCNT_RESET;
        end else if (w_cfg_wr && paddr[2] == cgr_pkg::REG_KEY_COUNT) begin
            // register keeps the raw bits; clamping happens at use
            r_key_count <= pwdata[cgr_pkg::KCNT_W-1:0];
        end
    end

    // read data for the key count word, zero elsewhere
    assign prdata = (paddr[2] == cgr_pkg::REG_KEY_COUNT)
                  ? {{(cgr_pkg::APB_DW - cgr_pkg::KCNT_W){1'b0}}, r_key_count}
                  : '0;

    // front end: take transfers, clamp times and ratios, queue them
    cgr_front #(
        .MAX_KEYS (MAX_KEYS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_ready (o_item_ready),
        .i_item       (i_item),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    // back end: key table, segment search, divide, mix, result register
    cgr_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_count (r_key_count),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .o_stat      (w_bstat)
    );

    // a result only appears after the back end has been busy
    a_res_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(!w_bstat.idle))
        else $error("result appeared without back end work");

    // an evaluate taken from the queue always starts the back end
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.kind == cgr_pkg::FUNC_EVAL) |=> !w_bstat.idle)
        else $error("evaluate transfer did not start the back end");

    // key count comes out of reset at its default
    a_kcnt_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_key_count == cgr_pkg::KCNT_RESET))
        else $error("key count not at reset value after reset");

endmodule
